/* hdl/tmc_pkg.sv */
package tmc_pkg;

    localparam int CHANNELS    = 4;
    localparam int DEPTH       = 16;
    localparam int CH_W        = $clog2(CHANNELS);
    localparam int SLOT_W      = $clog2(DEPTH);
    localparam int ADDR_W      = CH_W + SLOT_W;
    localparam int FILL_W      = $clog2(DEPTH + 1);
    localparam int MAX_OUT     = 16;
    localparam int CNT_W       = $clog2(MAX_OUT + 1);
    localparam int MS_TO_US    = 1000;
    localparam int DELAY_MS_W  = 16;
    localparam int DELAY_US_W  = 26;
    localparam int TOTAL_W     = 33;
    localparam int CFG_DATA_W  = 16;
    localparam int S_TDATA_W   = 184;
    localparam int M_TDATA_W   = 80;

    typedef enum logic [0:0] {
        MODE_INSERT = 1'b0,
        MODE_QUERY  = 1'b1
    } mode_t;

    localparam logic [0:0] REG_CACHE_DEPTH    = 1'b0;
    localparam logic [0:0] REG_ANALYTICS_DELAY = 1'b1;

    typedef struct packed {
        mode_t              mode;
        logic [CH_W-1:0]    channel;
        logic signed [63:0] timestamp;
        logic [31:0]        duration_us;
        logic               is_detection;
        logic [15:0]        handle;
        logic signed [63:0] range_end;
        logic [CNT_W-1:0]   max_count;
    } item_t;

    typedef struct packed {
        logic signed [63:0] start;
        logic [31:0]        length;
        logic               kind;
        logic [15:0]        id;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

/* hdl/tmc_ram.sv */
module tmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/tmc_front.sv */
module tmc_front import tmc_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // channel, timestamp, duration_us, is_detection, handle, range_end, max_count
    input  logic [S_TDATA_W-1:0] s_tdata,
    // mode
    input  logic [0:0]           s_tuser,
    output logic                 item_valid,
    input  logic                 item_ready,
    output item_t                item
);

    item_t      q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    item_t      in_item;
    logic       push;
    logic       pop;

    always_comb begin
        in_item.mode         = mode_t'(s_tuser[0]);
        in_item.channel      = s_tdata[CH_W-1:0];
        in_item.timestamp    = s_tdata[65:2];
        in_item.duration_us  = s_tdata[97:66];
        in_item.is_detection = s_tdata[98];
        in_item.handle       = s_tdata[114:99];
        in_item.range_end    = s_tdata[178:115];
        // query limit saturates at the result cap
        if (s_tdata[183:179] > CNT_W'(MAX_OUT)) begin
            in_item.max_count = CNT_W'(MAX_OUT);
        end else begin
            in_item.max_count = s_tdata[183:179];
        end
    end

    assign s_tready   = (cnt_reg != 2'd2);
    assign item_valid = (cnt_reg != 2'd0);
    assign item       = q_reg[rd_ptr_reg];
    assign push       = s_tvalid && s_tready;
    assign pop        = item_valid && item_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                q_reg[wr_ptr_reg] <= in_item;
                wr_ptr_reg        <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

/* hdl/tmc_back.sv */
module tmc_back import tmc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  item_t                 item,
    input  logic                  cfg_we,
    input  logic [0:0]            cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic [0:0]            m_tuser,
    output logic                  m_tlast
);

    typedef enum logic [6:0] {
        S_IDLE       = 7'b0000001,
        S_INS_SCAN   = 7'b0000010,
        S_INS_WRITE  = 7'b0000100,
        S_QRY_FIRST  = 7'b0001000,
        S_QRY_DECIDE = 7'b0010000,
        S_QRY_NEXT   = 7'b0100000,
        S_FINISH     = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [FILL_W-1:0]            depth_reg;
    logic [DELAY_MS_W-1:0]        delay_ms_reg;
    logic [DELAY_US_W-1:0]        delay_us_reg;
    logic [CHANNELS-1:0][DEPTH-1:0] vis_reg;
    logic [FILL_W-1:0]            fill_reg [CHANNELS];
    logic [SLOT_W-1:0]            oldest_reg [CHANNELS];

    item_t              item_reg;
    logic [SLOT_W:0]    scan_idx_reg;
    logic               rd_vld_reg;
    logic [SLOT_W-1:0]  rd_slot_reg;

    logic               pred_ok_reg, cand_ok_reg, cur_ok_reg, pend_ok_reg;
    logic signed [63:0] pred_start_reg, cand_start_reg, cur_start_reg, pend_start_reg;
    logic [15:0]        pred_id_reg, cand_id_reg, cur_id_reg, pend_id_reg;
    logic [TOTAL_W-1:0] pred_total_reg;
    logic [CNT_W-1:0]   count_reg;

    logic               out_valid_reg, out_found_reg, out_last_reg;
    logic [15:0]        out_handle_reg;
    logic signed [63:0] out_time_reg;

    entry_t             rd_entry;
    logic [ENTRY_W-1:0] rd_raw;
    entry_t             wr_entry;
    logic               ram_we;
    logic [SLOT_W-1:0]  wr_slot;
    logic               scan_active, issue, scan_done, hit_vis;
    logic               out_free, accept;
    logic [63:0]        pred_diff;
    logic               pred_covers, use_pred, emit;
    logic               push;
    logic               push_found, push_last;
    logic [15:0]        push_handle;
    logic signed [63:0] push_time;
    logic [FILL_W-1:0]  depth_sat;
    logic               depth_write;
    logic [FILL_W-1:0]  excess [CHANNELS];

    assign scan_active = (state_reg == S_INS_SCAN) || (state_reg == S_QRY_FIRST) ||
                         (state_reg == S_QRY_NEXT);
    assign issue       = scan_active && !scan_idx_reg[SLOT_W];
    assign scan_done   = scan_active && scan_idx_reg[SLOT_W] && !rd_vld_reg;
    assign rd_entry    = entry_t'(rd_raw);
    assign hit_vis     = rd_vld_reg && vis_reg[item_reg.channel][rd_slot_reg];
    assign out_free    = !out_valid_reg || m_tready;
    assign item_ready  = (state_reg == S_IDLE);
    assign accept      = item_valid && item_ready;

    assign wr_slot = oldest_reg[item_reg.channel] +
                     fill_reg[item_reg.channel][SLOT_W-1:0];
    assign ram_we  = (state_reg == S_INS_WRITE);
    always_comb begin
        wr_entry.start  = item_reg.timestamp;
        wr_entry.length = item_reg.duration_us;
        wr_entry.kind   = item_reg.is_detection;
        wr_entry.id     = item_reg.handle;
    end

    tmc_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(CHANNELS * DEPTH)
    ) u_entry_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr({item_reg.channel, wr_slot}),
        .wdata(wr_entry),
        .raddr({item_reg.channel, scan_idx_reg[SLOT_W-1:0]}),
        .rdata(rd_raw)
    );

    // predecessor covers the range start when start - pred lies inside its interval
    assign pred_diff   = item_reg.timestamp - pred_start_reg;
    assign pred_covers = (pred_total_reg != '0) && (pred_diff < 64'(pred_total_reg));
    assign use_pred    = pred_ok_reg && (!cand_ok_reg || cand_start_reg != item_reg.timestamp)
                         && pred_covers;
    assign emit        = cur_ok_reg && (cur_start_reg < item_reg.range_end) &&
                         (count_reg < item_reg.max_count);

    always_comb begin
        push        = 1'b0;
        push_found  = pend_ok_reg;
        push_handle = pend_ok_reg ? pend_id_reg : 16'd0;
        push_time   = pend_ok_reg ? pend_start_reg : 64'sd0;
        push_last   = 1'b1;
        if (state_reg == S_QRY_DECIDE && emit && pend_ok_reg && out_free) begin
            push      = 1'b1;
            push_last = 1'b0;
        end else if (state_reg == S_FINISH && out_free) begin
            push = 1'b1;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (item.mode == MODE_INSERT) begin
                        state_next = S_INS_SCAN;
                    end else if (item.max_count == '0) begin
                        state_next = S_FINISH;
                    end else begin
                        state_next = S_QRY_FIRST;
                    end
                end
            end
            S_INS_SCAN:  if (scan_done) state_next = S_INS_WRITE;
            S_INS_WRITE: state_next = S_IDLE;
            S_QRY_FIRST: if (scan_done) state_next = S_QRY_DECIDE;
            S_QRY_NEXT:  if (scan_done) state_next = S_QRY_DECIDE;
            S_QRY_DECIDE: begin
                if (!emit) begin
                    state_next = S_FINISH;
                end else if (!pend_ok_reg || out_free) begin
                    state_next = S_QRY_NEXT;
                end
            end
            S_FINISH:    if (out_free) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // depth writes saturate; lowering it trims the oldest entries of every channel
    always_comb begin
        depth_write = cfg_we && (cfg_addr == REG_CACHE_DEPTH) &&
                      (cfg_wdata[FILL_W-1:0] != '0);
        if (cfg_wdata[FILL_W-1:0] > FILL_W'(DEPTH)) begin
            depth_sat = FILL_W'(DEPTH);
        end else begin
            depth_sat = cfg_wdata[FILL_W-1:0];
        end
        for (int c = 0; c < CHANNELS; c++) begin
            excess[c] = fill_reg[c] - depth_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            depth_reg     <= FILL_W'(1);
            delay_ms_reg  <= '0;
            delay_us_reg  <= '0;
            vis_reg       <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                fill_reg[c]   <= '0;
                oldest_reg[c] <= '0;
            end
            item_reg      <= '0;
            scan_idx_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            pred_ok_reg   <= 1'b0;
            cand_ok_reg   <= 1'b0;
            cur_ok_reg    <= 1'b0;
            pend_ok_reg   <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            delay_us_reg <= DELAY_US_W'(delay_ms_reg) * DELAY_US_W'(MS_TO_US);

            rd_vld_reg  <= issue;
            rd_slot_reg <= scan_idx_reg[SLOT_W-1:0];
            if (issue) begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end

            if (accept) begin
                item_reg     <= item;
                scan_idx_reg <= '0;
                pred_ok_reg  <= 1'b0;
                cand_ok_reg  <= 1'b0;
                pend_ok_reg  <= 1'b0;
                count_reg    <= '0;
                if (item.mode == MODE_INSERT && fill_reg[item.channel] >= depth_reg) begin
                    vis_reg[item.channel][oldest_reg[item.channel]] <= 1'b0;
                    oldest_reg[item.channel] <= oldest_reg[item.channel] + 1'b1;
                    fill_reg[item.channel]   <= fill_reg[item.channel] - 1'b1;
                end
            end

            // an insert hides any visible entry with the same timestamp
            if (state_reg == S_INS_SCAN && hit_vis && rd_entry.start == item_reg.timestamp) begin
                vis_reg[item_reg.channel][rd_slot_reg] <= 1'b0;
            end
            if (state_reg == S_INS_WRITE) begin
                vis_reg[item_reg.channel][wr_slot] <= 1'b1;
                fill_reg[item_reg.channel] <= fill_reg[item_reg.channel] + 1'b1;
            end

            if (state_reg == S_QRY_FIRST && hit_vis) begin
                if (rd_entry.start < item_reg.timestamp) begin
                    if (!pred_ok_reg || rd_entry.start > pred_start_reg) begin
                        pred_ok_reg    <= 1'b1;
                        pred_start_reg <= rd_entry.start;
                        pred_id_reg    <= rd_entry.id;
                        pred_total_reg <= TOTAL_W'(rd_entry.length) +
                                          (rd_entry.kind ? TOTAL_W'(delay_us_reg) : '0);
                    end
                end else if (!cand_ok_reg || rd_entry.start < cand_start_reg) begin
                    cand_ok_reg    <= 1'b1;
                    cand_start_reg <= rd_entry.start;
                    cand_id_reg    <= rd_entry.id;
                end
            end
            if (state_reg == S_QRY_NEXT && hit_vis && rd_entry.start > cur_start_reg) begin
                if (!cand_ok_reg || rd_entry.start < cand_start_reg) begin
                    cand_ok_reg    <= 1'b1;
                    cand_start_reg <= rd_entry.start;
                    cand_id_reg    <= rd_entry.id;
                end
            end

            if (scan_done && state_reg == S_QRY_FIRST) begin
                cur_ok_reg    <= use_pred || cand_ok_reg;
                cur_start_reg <= use_pred ? pred_start_reg : cand_start_reg;
                cur_id_reg    <= use_pred ? pred_id_reg : cand_id_reg;
            end
            if (scan_done && state_reg == S_QRY_NEXT) begin
                cur_ok_reg    <= cand_ok_reg;
                cur_start_reg <= cand_start_reg;
                cur_id_reg    <= cand_id_reg;
            end

            // hold one result back so the final one can carry last
            if (state_reg == S_QRY_DECIDE && emit && (!pend_ok_reg || out_free)) begin
                pend_ok_reg    <= 1'b1;
                pend_start_reg <= cur_start_reg;
                pend_id_reg    <= cur_id_reg;
                count_reg      <= count_reg + 1'b1;
                cand_ok_reg    <= 1'b0;
                scan_idx_reg   <= '0;
            end

            if (push) begin
                out_valid_reg  <= 1'b1;
                out_found_reg  <= push_found;
                out_handle_reg <= push_handle;
                out_time_reg   <= push_time;
                out_last_reg   <= push_last;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_we && cfg_addr == REG_ANALYTICS_DELAY) begin
                delay_ms_reg <= cfg_wdata[DELAY_MS_W-1:0];
            end
            if (depth_write) begin
                depth_reg <= depth_sat;
                for (int c = 0; c < CHANNELS; c++) begin
                    if (fill_reg[c] > depth_sat) begin
                        oldest_reg[c] <= oldest_reg[c] + excess[c][SLOT_W-1:0];
                        fill_reg[c]   <= depth_sat;
                        for (int s = 0; s < DEPTH; s++) begin
                            if (FILL_W'(SLOT_W'(SLOT_W'(s) - oldest_reg[c])) < excess[c]) begin
                                vis_reg[c][s] <= 1'b0;
                            end
                        end
                    end
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_time_reg, out_handle_reg};
    assign m_tuser  = out_found_reg;
    assign m_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    a_fill_in_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> fill_reg[item_reg.channel] <= depth_reg)
        else $error("channel holds more entries than the cache depth");
    a_vis_le_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(vis_reg[item_reg.channel]) <= int'(fill_reg[item_reg.channel]))
        else $error("more visible entries than held entries");
    a_count_le_max: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_QRY_DECIDE |-> count_reg <= item_reg.max_count)
        else $error("query returned more entries than allowed");
    a_read_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_vld_reg |-> scan_active)
        else $error("read data returned outside a scan");
`endif

endmodule

/* hdl/timestamp_metadata_cache_core.sv */
// Per-channel metadata cache with range lookup. An insert accepts and evicts, sweeps
// the channel's 16 slots for an equal timestamp through the single read port of the
// entry memory, then writes. A query with a nonzero limit sweeps the 16 slots once to
// find the starting entry and once more for each entry returned, reading one slot per
// cycle from the entry memory. A two-deep input queue keeps accepting while the engine
// works, and an output register holds a result until it is taken. Configuration takes
// effect at the write edge and may only be written while the block is idle.
module timestamp_metadata_cache_core import tmc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // channel, timestamp, duration_us, is_detection, handle, range_end, max_count
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // mode
    input  logic [0:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // result_handle, result_time
    output logic [M_TDATA_W-1:0]  m_tdata,
    // found
    output logic [0:0]            m_tuser,
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [0:0]            cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic  item_valid;
    logic  item_ready;
    item_t item;

    tmc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item      (item)
    );

    tmc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

/* bench/tmc_checker.sv */
module tmc_checker import tmc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [0:0]            s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic [0:0]            m_tuser,
    input  logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [0:0]            cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    fails,
    output int                    pending,
    output int                    hits_seen,
    output int                    misses_seen
);

    typedef struct {
        logic               found;
        logic [15:0]        hdl;
        logic signed [63:0] ts;
        logic               last;
    } lookup_t;

    lookup_t lookup_q[$];

    logic signed [63:0] e_start [CHANNELS*DEPTH];
    logic [31:0]        e_len   [CHANNELS*DEPTH];
    logic               e_kind  [CHANNELS*DEPTH];
    logic [15:0]        e_id    [CHANNELS*DEPTH];
    bit                 e_vis   [CHANNELS*DEPTH];
    int                 oldest  [CHANNELS];
    int                 fill    [CHANNELS];
    int                 depth_cfg;
    logic [15:0]        delay_cfg;

    task automatic report(input string msg);
        if (fails < 20) $display("mismatch at %0t: %s", $realtime, msg);
        fails++;
    endtask

    task automatic drop_oldest(input int ch);
        if (fill[ch] != 0) begin
            e_vis[ch*DEPTH + oldest[ch]] = 0;
            oldest[ch] = (oldest[ch] + 1) % DEPTH;
            fill[ch]--;
        end
    endtask

    function automatic bit covers(input int s, input logic signed [63:0] t);
        logic [63:0] total;
        logic [63:0] diff;
        total = {32'b0, e_len[s]};
        if (e_kind[s]) total = total + 64'(delay_cfg) * 64'(MS_TO_US);
        if (total == 0) return t == e_start[s];
        if (t < e_start[s]) return 0;
        diff = t - e_start[s];
        return diff < total;
    endfunction

    task automatic store_item(input int ch, input logic signed [63:0] ts,
                              input logic [31:0] dur, input logic det,
                              input logic [15:0] hdl);
        int base;
        int s;
        base = ch * DEPTH;
        if (fill[ch] >= depth_cfg) drop_oldest(ch);
        for (int k = 0; k < DEPTH; k++)
            if (e_vis[base+k] && e_start[base+k] == ts) e_vis[base+k] = 0;
        s = (oldest[ch] + fill[ch]) % DEPTH;
        e_start[base+s] = ts;
        e_len[base+s]   = dur;
        e_kind[base+s]  = det;
        e_id[base+s]    = hdl;
        e_vis[base+s]   = 1;
        fill[ch]++;
    endtask

    task automatic lookup_range(input int ch, input logic signed [63:0] ts,
                                input logic signed [63:0] rend, input int maxc_in);
        int srt [DEPTH];
        int n;
        int j;
        int i;
        int cnt;
        int base;
        int maxc;
        lookup_t r;
        base = ch * DEPTH;
        n = 0;
        cnt = 0;
        maxc = (maxc_in > MAX_OUT) ? MAX_OUT : maxc_in;
        for (int s = 0; s < DEPTH; s++) begin
            if (e_vis[base+s]) begin
                j = n;
                while (j > 0 && e_start[base+s] < e_start[base+srt[j-1]]) begin
                    srt[j] = srt[j-1];
                    j--;
                end
                srt[j] = s;
                n++;
            end
        end
        i = 0;
        while (i < n && e_start[base+srt[i]] < ts) i++;
        // entry just below the range start may still be valid at it
        if (i > 0 && (i == n || e_start[base+srt[i]] != ts))
            if (covers(base + srt[i-1], ts)) i--;
        while (cnt < maxc && i < n && e_start[base+srt[i]] < rend) begin
            r.found = 1;
            r.hdl   = e_id[base+srt[i]];
            r.ts    = e_start[base+srt[i]];
            r.last  = 0;
            lookup_q.push_back(r);
            cnt++;
            i++;
        end
        if (cnt == 0) begin
            r.found = 0;
            r.hdl   = 0;
            r.ts    = 0;
            r.last  = 1;
            lookup_q.push_back(r);
        end else begin
            lookup_q[$].last = 1;
        end
    endtask

    always @(posedge aclk) begin
        lookup_t exp_r;
        int d;
        if (!aresetn) begin
            lookup_q.delete();
            for (int k = 0; k < CHANNELS*DEPTH; k++) e_vis[k] = 0;
            for (int c = 0; c < CHANNELS; c++) begin
                oldest[c] = 0;
                fill[c] = 0;
            end
            depth_cfg = 1;
            delay_cfg = 0;
        end else begin
            if (cfg_we) begin
                if (cfg_addr == REG_CACHE_DEPTH) begin
                    d = int'(cfg_wdata & 16'h1f);
                    if (d != 0) begin
                        if (d > DEPTH) d = DEPTH;
                        depth_cfg = d;
                        for (int c = 0; c < CHANNELS; c++)
                            while (fill[c] > depth_cfg) drop_oldest(c);
                    end
                end else begin
                    delay_cfg = cfg_wdata;
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == MODE_INSERT)
                    store_item(int'(s_tdata[1:0]), s_tdata[65:2], s_tdata[97:66],
                               s_tdata[98], s_tdata[114:99]);
                else
                    lookup_range(int'(s_tdata[1:0]), s_tdata[65:2], s_tdata[178:115],
                                 int'(s_tdata[183:179]));
            end
            if (m_tvalid && m_tready) begin
                if (lookup_q.size() == 0) begin
                    report("result transaction with nothing expected");
                end else begin
                    exp_r = lookup_q.pop_front();
                    if (m_tuser[0] !== exp_r.found)
                        report($sformatf("found %b, want %b", m_tuser[0], exp_r.found));
                    if (m_tdata[15:0] !== exp_r.hdl)
                        report($sformatf("handle %h, want %h", m_tdata[15:0], exp_r.hdl));
                    if (m_tdata[79:16] !== exp_r.ts)
                        report($sformatf("time %0d, want %0d",
                                         $signed(m_tdata[79:16]), exp_r.ts));
                    if (m_tlast !== exp_r.last)
                        report($sformatf("last %b, want %b", m_tlast, exp_r.last));
                    if (exp_r.found) hits_seen++;
                    else misses_seen++;
                end
            end
        end
        pending = lookup_q.size();
    end

    initial begin
        fails = 0;
        pending = 0;
        hits_seen = 0;
        misses_seen = 0;
    end

endmodule

/* bench/testbench.sv */
module testbench;
    import tmc_pkg::*;

    localparam int IDLE_LIMIT = 5000;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [0:0]            m_tuser;
    logic                  m_tlast;
    logic                  cfg_we;
    logic [0:0]            cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int  fails;
    int  pending;
    int  hits_seen;
    int  misses_seen;
    int  items_sent;
    int  idle_cycles;
    bit  no_idle;

    timestamp_metadata_cache_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    tmc_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .fails(fails), .pending(pending), .hits_seen(hits_seen), .misses_seen(misses_seen)
    );

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    // watchdog: cycles with no transaction on any port
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout waiting for a transaction");
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_item(input mode_t mode, input logic [1:0] ch,
                             input logic [63:0] ts, input logic [31:0] dur,
                             input logic det, input logic [15:0] hdl,
                             input logic [63:0] rend, input logic [4:0] maxc);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid = 0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1;
        s_tuser  = mode;
        s_tdata  = {maxc, rend, hdl, det, dur, ts, ch};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic write_reg(input logic [0:0] addr, input logic [15:0] val);
        s_tvalid = 0;
        while (pending != 0) @(negedge aclk);
        // inserts leave nothing to wait for, so let the engine drain
        repeat (120) @(negedge aclk);
        cfg_we    = 1;
        cfg_addr  = addr;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_we = 0;
    endtask

    function automatic logic [63:0] pick_ts();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0) return {$urandom, $urandom};
        if (sel == 1) return 64'h8000_0000_0000_0000;
        if (sel == 2) return 64'h7fff_ffff_ffff_ffff;
        if (sel < 10) return 64'(1000 + $urandom_range(0, 3000));
        if (sel < 15) return -64'(5000) + 64'($urandom_range(0, 3000));
        return 64'd1_000_000_000 + 64'($urandom_range(0, 3000));
    endfunction

    function automatic logic [31:0] pick_dur();
        case ($urandom_range(0, 7))
            0, 1:    return 0;
            2:       return $urandom;
            3:       return 32'hffff_ffff;
            default: return $urandom_range(1, 2000);
        endcase
    endfunction

    task automatic random_item();
        int sel;
        logic [63:0] ts;
        logic [63:0] rend;
        logic [4:0]  maxc;
        sel = $urandom_range(0, 99);
        ts = pick_ts();
        if (sel < 5) begin
            send_item(mode_t'($urandom_range(0, 1)), 2'($urandom), {$urandom, $urandom},
                      $urandom, 1'($urandom), 16'($urandom), {$urandom, $urandom},
                      5'($urandom));
        end else if (sel < 60) begin
            send_item(MODE_INSERT, 2'($urandom_range(0, 3)), ts, pick_dur(),
                      1'($urandom), 16'($urandom), {$urandom, $urandom}, 5'($urandom));
        end else begin
            rend = ($urandom_range(0, 9) == 0) ? pick_ts() : ts + $urandom_range(0, 4000);
            maxc = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(1, 16));
            send_item(MODE_QUERY, 2'($urandom_range(0, 3)), ts, $urandom, 1'($urandom),
                      16'($urandom), rend, maxc);
        end
    endtask

    initial begin
        logic [15:0] depths [8];
        logic [15:0] delays [8];
        depths = '{16'd16, 16'd4, 16'd31, 16'd0, 16'd2, 16'd1, 16'h0023, 16'd8};
        delays = '{16'd0, 16'd1, 16'd65535, 16'd7, 16'd500, 16'd65535, 16'd0, 16'd12};
        items_sent = 0;
        idle_cycles = 0;
        no_idle   = 0;
        s_tvalid  = 0;
        s_tdata   = '0;
        s_tuser   = MODE_INSERT;
        cfg_we    = 0;
        cfg_addr  = REG_CACHE_DEPTH;
        cfg_wdata = 0;
        aresetn   = 0;
        repeat (10) @(negedge aclk);
        aresetn = 1;

        // empty cache, then depth one keeps only the newest
        send_item(MODE_QUERY, 0, 64'd0, 0, 0, 0, 64'h7fff_ffff_ffff_ffff, 16);
        send_item(MODE_INSERT, 0, 64'd100, 0, 0, 16'h0001, 0, 0);
        send_item(MODE_INSERT, 0, 64'd200, 0, 0, 16'h0002, 0, 0);
        send_item(MODE_QUERY, 0, 64'd0, 0, 0, 0, 64'd1000, 16);

        for (int p = 0; p < 8; p++) begin
            write_reg(REG_CACHE_DEPTH, depths[p]);
            write_reg(REG_ANALYTICS_DELAY, delays[p]);
            no_idle = (p == 3);
            if (p == 0) begin
                send_item(MODE_INSERT, 1, 64'h8000_0000_0000_0000, 32'hffff_ffff, 1,
                          16'hffff, 0, 0);
                send_item(MODE_INSERT, 1, 64'h7fff_ffff_ffff_ffff, 0, 0, 16'h0000, 0, 0);
                send_item(MODE_INSERT, 1, 64'd0, 0, 0, 16'h1234, 0, 0);
                send_item(MODE_INSERT, 1, 64'd50, 100, 0, 16'h0050, 0, 0);
                // same timestamp again: the newer one is visible
                send_item(MODE_INSERT, 1, 64'd0, 0, 1, 16'h4321, 0, 0);
                send_item(MODE_QUERY, 1, 64'h8000_0000_0000_0000, 0, 0, 0,
                          64'h7fff_ffff_ffff_ffff, 16);
                send_item(MODE_QUERY, 1, 64'd120, 0, 0, 0, 64'd200, 16);
                send_item(MODE_QUERY, 1, 64'd160, 0, 0, 0, 64'd200, 16);
                send_item(MODE_QUERY, 1, 64'd1, 0, 0, 0, 64'd2, 16);
                send_item(MODE_QUERY, 1, -64'd10, 0, 0, 0, 64'd60, 1);
                send_item(MODE_QUERY, 1, -64'd10, 0, 0, 0, 64'd60, 0);
                send_item(MODE_QUERY, 1, 64'h8000_0000_0000_0000, 0, 0, 0,
                          64'h7fff_ffff_ffff_ffff, 31);
                send_item(MODE_QUERY, 1, 64'd100, 0, 0, 0, 64'd10, 16);
                send_item(MODE_INSERT, 3, 64'd7, 0, 1, 16'haaaa, 0, 0);
                send_item(MODE_QUERY, 3, 64'd7, 0, 0, 0, 64'd8, 16);
                send_item(MODE_QUERY, 2, 64'd7, 0, 0, 0, 64'd8, 16);
            end
            for (int k = 0; k < 52; k++) random_item();
        end

        s_tvalid = 0;
        while (pending != 0) @(negedge aclk);
        repeat (400) @(negedge aclk);
        $display("sent %0d items over 8 register settings; %0d hits and %0d empty answers",
                 items_sent, hits_seen, misses_seen);
        if (fails == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        int gap;
        m_tready = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            gap = no_idle ? 0 : $urandom_range(0, 9);
            if (gap > 0) begin
                m_tready = 0;
                repeat (gap) @(negedge aclk);
            end
            m_tready = 1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

endmodule
